/* design/cdq_pkg.sv */
// shared types and constants of the circular deque
package cdq_pkg;

   localparam int SLOTS  = 8;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DATA_W = 32;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef enum logic [2:0] {
      OP_PUSH_REAR  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_REAR  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [DATA_W-1:0] wdata;
      logic              re;
      logic [IDX_W-1:0]  raddr;
   } ram_req_type;

   typedef struct packed {
      logic       valid;
      logic       use_read;
      status_type status;
      logic       now_empty;
      logic       now_full;
   } rsp_info_type;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : IDX_W'(i + 1'b1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST_IDX : IDX_W'(i - 1'b1);
   endfunction

endpackage

/* design/cdq_ram.sv */
// generic single-write, single-read ram with registered read data
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/cdq_ctrl.sv */
// pointer control: checks, pointer update and ram access per operation
module cdq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_operation,
   input  logic [cdq_pkg::DATA_W-1:0]    req_push_value,
   output cdq_pkg::ram_req_type          ram_req,
   output cdq_pkg::rsp_info_type         rsp_info
);

   import cdq_pkg::*;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             busy_ff;
   rsp_info_type     info_ff, info_in;
   logic             accept;
   logic             deque_empty;
   logic             is_full;
   status_type       status;
   logic             use_read;

   assign accept      = start & ~busy_ff;
   assign deque_empty = (head_ff == tail_ff);
   assign is_full     = (ring_next(tail_ff) == head_ff);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      status        = ST_OK;
      use_read      = 1'b0;
      ram_req.we    = 1'b0;
      ram_req.waddr = tail_ff;
      ram_req.wdata = req_push_value;
      ram_req.re    = 1'b0;
      ram_req.raddr = tail_ff;
      unique case (req_operation)
         OP_PUSH_REAR: begin
            if (is_full) begin
               status = ST_OVERFLOW;
            end else begin
               tail_in       = ring_next(tail_ff);
               ram_req.we    = accept;
               ram_req.waddr = ring_next(tail_ff);
            end
         end
         OP_PUSH_FRONT: begin
            if (is_full) begin
               status = ST_OVERFLOW;
            end else begin
               head_in       = ring_prev(head_ff);
               ram_req.we    = accept;
               ram_req.waddr = head_ff;
            end
         end
         OP_POP_FRONT: begin
            if (deque_empty) begin
               status = ST_UNDERFLOW;
            end else begin
               head_in       = ring_next(head_ff);
               use_read      = 1'b1;
               ram_req.re    = accept;
               ram_req.raddr = ring_next(head_ff);
            end
         end
         OP_POP_REAR: begin
            if (deque_empty) begin
               status = ST_UNDERFLOW;
            end else begin
               tail_in       = ring_prev(tail_ff);
               use_read      = 1'b1;
               ram_req.re    = accept;
               ram_req.raddr = tail_ff;
            end
         end
         OP_PEEK_FRONT: begin
            if (deque_empty) begin
               status = ST_UNDERFLOW;
            end else begin
               use_read      = 1'b1;
               ram_req.re    = accept;
               ram_req.raddr = ring_next(head_ff);
            end
         end
         OP_PEEK_REAR: begin
            if (deque_empty) begin
               status = ST_UNDERFLOW;
            end else begin
               use_read      = 1'b1;
               ram_req.re    = accept;
               ram_req.raddr = tail_ff;
            end
         end
         default: begin
         end
      endcase

      info_in.valid     = accept;
      info_in.use_read  = use_read;
      info_in.status    = status;
      info_in.now_empty = (head_in == tail_in);
      info_in.now_full  = (ring_next(tail_in) == head_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         busy_ff       <= 1'b1;
         info_ff.valid <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         info_ff.valid <= info_in.valid;
         if (accept) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
         end
      end
      info_ff.use_read  <= info_in.use_read;
      info_ff.status    <= info_in.status;
      info_ff.now_empty <= info_in.now_empty;
      info_ff.now_full  <= info_in.now_full;
   end

   assign busy     = busy_ff;
   assign rsp_info = info_ff;

endmodule

/* design/circular_deque.sv */
// circular deque top level: pointer control and ring memory
// A deque of SLOTS 32-bit words kept in a ring memory, one slot always unused,
// so it holds at most SLOTS-1 words. An operation is taken at a clock edge with
// start high and busy low; its result is on the rsp_ ports for exactly one
// cycle, marked by rsp_valid, in the cycle right after the transfer, and must
// be captured then. One operation can be taken every cycle: each operation
// touches the ring memory at most once (one write for a push, one registered
// read for a pop or peek), and the read data leaves straight from the memory's
// output register. busy is high only during reset and the first cycle after it.
// Pushes, errors and unused operation codes return zero in rsp_read_value.
module circular_deque (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [2:0]                         req_operation,
   input  logic signed [cdq_pkg::DATA_W-1:0]  req_push_value,
   output logic                               rsp_valid,
   output logic signed [cdq_pkg::DATA_W-1:0]  rsp_read_value,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_now_empty,
   output logic                               rsp_now_full
);

   import cdq_pkg::*;

   ram_req_type       ram_req;
   rsp_info_type      rsp_info;
   logic [DATA_W-1:0] ram_rdata;

   cdq_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_push_value (req_push_value),
      .ram_req        (ram_req),
      .rsp_info       (rsp_info)
   );

   cdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SLOTS),
      .AW    (IDX_W)
   ) u_ring (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid      = rsp_info.valid;
   assign rsp_read_value = rsp_info.use_read ? ram_rdata : '0;
   assign rsp_status     = rsp_info.status;
   assign rsp_now_empty  = rsp_info.now_empty;
   assign rsp_now_full   = rsp_info.now_full;

endmodule
